[rtl/pdt_pkg.sv]
// Shared constants of the piezo drum trigger detector.
`default_nettype none

package pdt_pkg;

    localparam int NUM_PADS_DEF    = 6;
    localparam int STORE_DEPTH_DEF = 128;

    localparam int PAD_W    = 3;
    localparam int SAMPLE_W = 10;
    localparam int TIME_W   = 32;
    localparam int FIELD_W  = 7;
    localparam int TABLE_W  = 42;
    localparam int GAP_W    = 16;
    localparam int CH_W     = 4;
    localparam int STATUS_W = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MIDI_CHANNEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLDS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTES        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOTE_GAP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_GAP     = 3'd4;

    localparam logic [STATUS_W-1:0] NOTE_ON_STATUS  = 8'h90;
    localparam logic [STATUS_W-1:0] NOTE_OFF_STATUS = 8'h80;
    localparam logic [SAMPLE_W-1:0] VELOCITY_MAX    = 10'd127;

    localparam logic [CH_W-1:0]    RESET_CHANNEL    = 4'd0;
    localparam logic [TABLE_W-1:0] RESET_THRESHOLDS = 42'd1039056572210;
    localparam logic [TABLE_W-1:0] RESET_NOTES      = 42'd2458486219851;
    localparam logic [GAP_W-1:0]   RESET_NOTE_GAP   = 16'd50;
    localparam logic [GAP_W-1:0]   RESET_PEAK_GAP   = 16'd20;

endpackage

`default_nettype wire

[rtl/pdt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/piezo_drum_trigger_detector.sv]
// Top level of the piezo drum trigger detector: sample store walk and note firing.
// Steps: accept and pad state read, then a load step that writes the store; a below-threshold
// sample may go on to a backward walk over the stored samples (up to STORE_DEPTH) and a peak step.
// A new sample is accepted only in idle, once the previous one is done; the sample store
// read port sets the walk at one entry per cycle.
// A fired note adds two output beats, note-on then note-off, each held while the receiver stalls.
// Reset is synchronous; per-pad valid bits and a ring wrap flag stand in for clearing.
`default_nettype none

module piezo_drum_trigger_detector
    import pdt_pkg::*;
#(
    parameter int NUM_PADS    = NUM_PADS_DEF,
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,

    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [TABLE_W-1:0]   i_cfg_data,

    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [PAD_W-1:0]     i_pad,
    input  wire logic [SAMPLE_W-1:0]  i_sample,
    input  wire logic [TIME_W-1:0]    i_time_ms,

    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [STATUS_W-1:0]       o_status_byte,
    output logic [FIELD_W-1:0]        o_note,
    output logic [FIELD_W-1:0]        o_velocity,
    output logic                      o_last
);

    localparam int PAD_AW  = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;
    localparam int IDX_W   = $clog2(STORE_DEPTH);
    localparam int ADDR_W  = $clog2(NUM_PADS * STORE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(STORE_DEPTH - 1);

    typedef struct packed {
        logic [IDX_W-1:0]    wr_idx;
        logic                wrapped;
        logic [SAMPLE_W-1:0] prev_peak;
        logic                armed;
        logic [SAMPLE_W-1:0] armed_vel;
        logic                peak_zero;
        logic [TIME_W-1:0]   peak_time;
        logic [TIME_W-1:0]   note_time;
    } t_pad_state;

    localparam int PS_W = $bits(t_pad_state);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_LOAD = 6'b000010,
        S_WALK = 6'b000100,
        S_PEAK = 6'b001000,
        S_ON   = 6'b010000,
        S_OFF  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [CH_W-1:0]    r_channel;
    logic [TABLE_W-1:0] r_thresholds;
    logic [TABLE_W-1:0] r_notes;
    logic [GAP_W-1:0]   r_note_gap;
    logic [GAP_W-1:0]   r_peak_gap;

    logic [PAD_W-1:0]    r_pad;
    logic [SAMPLE_W-1:0] r_sample;
    logic [TIME_W-1:0]   r_time;
    logic [NUM_PADS-1:0] r_pad_valid;

    t_pad_state r_ps, n_ps, ps_cur, ps_rst, ps_rd;
    logic [IDX_W-1:0]    r_j, n_j;
    logic [SAMPLE_W-1:0] r_peak, n_peak;
    logic [SAMPLE_W-1:0] r_vel, n_vel;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [FIELD_W-1:0]  r_out_note;
    logic [FIELD_W-1:0]  r_out_vel;
    logic                r_out_last;

    logic [PS_W-1:0]     ps_rdata;
    logic                ps_we;
    logic [PAD_AW-1:0]   ps_raddr;
    logic [PAD_AW-1:0]   pad_idx;

    logic                st_we;
    logic [ADDR_W-1:0]   st_base, st_waddr, st_raddr;
    logic [SAMPLE_W-1:0] st_rdata;

    logic                in_accept, pad_ok, out_free;
    logic [SAMPLE_W-1:0] thr;
    logic [FIELD_W-1:0]  pad_note;
    logic [SAMPLE_W-1:0] walk_max;
    logic [TIME_W-1:0]   peak_age, note_age;
    logic                fire;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);
    assign pad_ok      = (i_pad < PAD_W'(NUM_PADS));
    assign in_accept   = i_valid && o_ready;
    assign out_free    = !r_out_valid || i_ready;

    assign pad_idx  = r_pad[PAD_AW-1:0];
    assign ps_raddr = i_pad[PAD_AW-1:0];
    assign thr      = SAMPLE_W'(r_thresholds[r_pad * FIELD_W +: FIELD_W]);
    assign pad_note = r_notes[r_pad * FIELD_W +: FIELD_W];
    assign st_base  = ADDR_W'(r_pad) * ADDR_W'(STORE_DEPTH);

    assign ps_rd = t_pad_state'(ps_rdata);

    always_comb begin
        ps_rst           = '0;
        ps_rst.peak_zero = 1'b1;
        ps_cur           = r_pad_valid[pad_idx] ? ps_rd : ps_rst;
    end

    pdt_ram #(
        .WIDTH (PS_W),
        .DEPTH (NUM_PADS)
    ) u_pad_ram (
        .i_clk   (i_clk),
        .i_we    (ps_we),
        .i_waddr (pad_idx),
        .i_wdata (PS_W'(n_ps)),
        .i_raddr (ps_raddr),
        .o_rdata (ps_rdata)
    );

    pdt_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (NUM_PADS * STORE_DEPTH)
    ) u_store_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (st_waddr),
        .i_wdata (r_sample),
        .i_raddr (st_raddr),
        .o_rdata (st_rdata)
    );

    assign st_waddr = st_base + ADDR_W'(ps_cur.wr_idx);
    assign st_raddr = st_base + ADDR_W'(n_j);
    assign walk_max = (st_rdata > r_peak) ? st_rdata : r_peak;
    assign peak_age = r_time - ps_cur.peak_time;
    assign note_age = r_time - r_ps.note_time;
    assign fire     = (r_peak < r_ps.prev_peak) && r_ps.armed;

    always_comb begin
        n_state = r_state;
        n_ps    = r_ps;
        n_j     = r_j;
        n_peak  = r_peak;
        n_vel   = r_vel;
        ps_we   = 1'b0;
        st_we   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_accept && pad_ok) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                st_we  = 1'b1;
                ps_we  = 1'b1;
                n_ps   = ps_cur;
                n_peak = '0;
                if (ps_cur.wr_idx == IDX_LAST) begin
                    n_ps.wr_idx  = '0;
                    n_ps.wrapped = 1'b1;
                end else begin
                    n_ps.wr_idx = ps_cur.wr_idx + IDX_W'(1);
                end
                if (r_sample >= thr) begin
                    n_state = S_IDLE;
                end else if (!ps_cur.peak_zero && (peak_age > TIME_W'(r_peak_gap))) begin
                    n_state = S_PEAK;
                end else if (ps_cur.wr_idx == '0 && !ps_cur.wrapped) begin
                    n_state = S_IDLE;
                end else begin
                    n_j     = (ps_cur.wr_idx == '0) ? IDX_LAST : ps_cur.wr_idx - IDX_W'(1);
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (st_rdata >= thr) begin
                    n_peak = walk_max;
                    if (r_j == '0 && !r_ps.wrapped) begin
                        n_state = (walk_max != '0) ? S_PEAK : S_IDLE;
                    end else begin
                        n_j = (r_j == '0) ? IDX_LAST : r_j - IDX_W'(1);
                    end
                end else begin
                    n_state = (r_peak != '0) ? S_PEAK : S_IDLE;
                end
            end
            S_PEAK: begin
                ps_we          = 1'b1;
                n_ps.peak_zero = (r_peak == '0);
                n_ps.peak_time = r_time;
                n_ps.prev_peak = r_peak;
                n_state        = S_IDLE;
                if ((r_peak > r_ps.prev_peak) && (note_age > TIME_W'(r_note_gap))) begin
                    n_ps.armed = 1'b1;
                    if (r_peak > r_ps.armed_vel) begin
                        n_ps.armed_vel = r_peak;
                    end
                end else if (fire) begin
                    n_vel          = (r_ps.armed_vel > VELOCITY_MAX) ? VELOCITY_MAX
                                                                     : r_ps.armed_vel;
                    n_ps.armed     = 1'b0;
                    n_ps.armed_vel = '0;
                    n_ps.note_time = r_time;
                    n_state        = S_ON;
                end
            end
            S_ON: begin
                if (out_free) begin
                    n_state = S_OFF;
                end
            end
            S_OFF: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pad_valid  <= '0;
            r_out_valid  <= 1'b0;
            r_channel    <= RESET_CHANNEL;
            r_thresholds <= RESET_THRESHOLDS;
            r_notes      <= RESET_NOTES;
            r_note_gap   <= RESET_NOTE_GAP;
            r_peak_gap   <= RESET_PEAK_GAP;
        end else begin
            r_state <= n_state;
            if (ps_we) begin
                r_pad_valid[pad_idx] <= 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MIDI_CHANNEL: r_channel    <= i_cfg_data[CH_W-1:0];
                    CFG_THRESHOLDS:   r_thresholds <= i_cfg_data;
                    CFG_NOTES:        r_notes      <= i_cfg_data;
                    CFG_NOTE_GAP:     r_note_gap   <= i_cfg_data[GAP_W-1:0];
                    CFG_PEAK_GAP:     r_peak_gap   <= i_cfg_data[GAP_W-1:0];
                    default: begin
                    end
                endcase
            end
            if ((r_state == S_ON || r_state == S_OFF) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_pad    <= i_pad;
            r_sample <= i_sample;
            r_time   <= i_time_ms;
        end
        r_ps   <= n_ps;
        r_j    <= n_j;
        r_peak <= n_peak;
        r_vel  <= n_vel;
        if ((r_state == S_ON || r_state == S_OFF) && out_free) begin
            r_out_status <= ((r_state == S_ON) ? NOTE_ON_STATUS : NOTE_OFF_STATUS)
                            + STATUS_W'(r_channel);
            r_out_note   <= pad_note;
            r_out_vel    <= r_vel[FIELD_W-1:0];
            r_out_last   <= (r_state == S_OFF);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status_byte = r_out_status;
    assign o_note        = r_out_note;
    assign o_velocity    = r_out_vel;
    assign o_last        = r_out_last;

    a_note_off_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last && i_ready) |=> (o_valid && o_last))
        else $error("note-off beat does not follow note-on");

    a_peak_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PEAK) |-> ($past(r_state) == S_LOAD || $past(r_state) == S_WALK))
        else $error("peak step entered from wrong state");

    a_walk_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK || r_state == S_LOAD) |-> (r_pad < PAD_W'(NUM_PADS)))
        else $error("store access for pad out of range");

    a_walk_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_sample < thr))
        else $error("walk started for sample at or above threshold");

endmodule

`default_nettype wire
